// ===== hdl/fsp2_pkg.sv =====
package fsp2_pkg;
    localparam int unsigned ExpMax = 255;
    localparam int unsigned BeW    = 18;

    typedef logic [31:0] t_word;
    typedef logic signed [BeW-1:0] t_bexp;
endpackage

// ===== hdl/float_scale_by_power_of_two.sv =====
// Channel | Valid   | Stall   | Payload
// input   | i_valid | o_stall | i_value_bits, i_scale_exponent
// output  | o_valid | i_stall | o_result_bits
// One transaction per cycle while the output is not stalled; data passes the input register, then the result register.
// The exponent adjust, normalise and round sit between the two registers.
// Reset (i_rst_n low, synchronous) empties both stages.
// The input register is held while it is full and the result register is stalled and full.
module float_scale_by_power_of_two (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  fsp2_pkg::t_word      i_value_bits,
    input  logic signed [15:0]   i_scale_exponent,
    output logic                 o_valid,
    input  logic                 i_stall,
    output fsp2_pkg::t_word      o_result_bits
);
    import fsp2_pkg::*;

    logic               r_v1;
    logic               r_v2;
    t_word              r_x;
    logic signed [15:0] r_n;
    t_word              r_res;
    t_word              n_res;
    logic               adv2;
    logic               adv1;

    assign adv2    = r_v1 && (!r_v2 || !i_stall);
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_v2;
    assign o_result_bits = r_res;

    fsp2_core u_core (
        .i_value_bits    (r_x),
        .i_scale_exponent(r_n),
        .o_result_bits   (n_res)
    );

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= 1'b1;
            else if (!i_stall) r_v2 <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_x <= i_value_bits;
            r_n <= i_scale_exponent;
        end
        if (adv2) r_res <= n_res;
    end

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && i_stall))
        else $error("stall with free stage");
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted transaction lost");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv2 |=> o_valid)
        else $error("result not presented");
endmodule

// ===== hdl/fsp2_core.sv =====
module fsp2_core (
    input  fsp2_pkg::t_word      i_value_bits,
    input  logic signed [15:0]   i_scale_exponent,
    output fsp2_pkg::t_word      o_result_bits
);
    import fsp2_pkg::*;

    logic        sgn;
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [4:0]  lz;
    logic [23:0] sig;
    t_bexp       be;
    t_bexp       n_ext;
    logic [4:0]  sh;
    logic [48:0] shifted;
    logic [23:0] q;
    logic        rnd_up;
    logic [23:0] q_rnd;
    t_word       packed_res;

    assign sgn   = i_value_bits[31];
    assign expo  = i_value_bits[30:23];
    assign frac  = i_value_bits[22:0];
    assign n_ext = BeW'(i_scale_exponent);

    // leading zero count of the fraction for denormal operands
    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (frac[i]) lz = 5'(22 - i);
        end
    end

    // significand with hidden bit and biased-plus-n exponent
    always_comb begin
        if (expo == 8'd0) begin
            sig = {1'b0, frac} << (lz + 5'd1);
            be  = n_ext - BeW'(lz);
        end else begin
            sig = {1'b1, frac};
            be  = n_ext + BeW'(expo);
        end
    end

    // denormal range: shift right by 1-be, round to nearest even
    assign sh      = 5'(BeW'(1) - be);
    assign shifted = {sig, 25'd0} >> sh;
    assign q       = shifted[48:25];
    assign rnd_up  = shifted[24] && ((|shifted[23:0]) || q[0]);
    assign q_rnd   = q + {23'd0, rnd_up};

    // signed compare throughout: a negative exponent must not read as overflow
    always_comb begin
        if (be >= t_bexp'(ExpMax))
            packed_res = {sgn, 8'hFF, 23'd0};
        else if (be >= BeW'(1))
            packed_res = {sgn, be[7:0], sig[22:0]};
        else if (be < -BeW'(24))
            packed_res = {sgn, 31'd0};
        else
            packed_res = {sgn, 7'd0, q_rnd};
    end

    // specials pass through; deep underflow flushes to signed zero
    always_comb begin
        if (expo == 8'(ExpMax) || (expo == 8'd0 && frac == 23'd0))
            o_result_bits = i_value_bits;
        else if (expo == 8'd0 && i_scale_exponent <= -16'sd23)
            o_result_bits = {sgn, 31'd0};
        else if (expo != 8'd0 && be <= -BeW'(23))
            o_result_bits = {sgn, 31'd0};
        else
            o_result_bits = packed_res;
    end
endmodule
